// ----- rtl/mono_bitmap_color_expand_assert.svh -----
// ---------------------------------------------------------------------------
// Assertion macros
// Shared assertion macros for the color expansion block.
// ---------------------------------------------------------------------------
`ifndef MONO_BITMAP_COLOR_EXPAND_ASSERT_SVH
`define MONO_BITMAP_COLOR_EXPAND_ASSERT_SVH

// Checked only while out of reset.
`define MBCE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every edge, reset included.
`define MBCE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ----- rtl/mbce_pkg.sv -----
// ---------------------------------------------------------------------------
// mbce_pkg
// Shared types and constants of the monochrome bitmap color expander.
// ---------------------------------------------------------------------------
package mbce_pkg;

  localparam int unsigned QUEUE_DEPTH     = 2;
  localparam int unsigned COORD_W         = 16;
  localparam int unsigned COLOR_W         = 24;
  localparam int unsigned CFG_IDX_W       = 2;
  localparam logic [COLOR_W-1:0] COLOR_ONE_RESET = 24'hFF_FFFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ORIGIN_ROW = 2'd0,
    CFG_ORIGIN_COL = 2'd1,
    CFG_COLOR_ZERO = 2'd2,
    CFG_COLOR_ONE  = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0]         bits;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic               last_img;
  } mbce_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } mbce_fifo_status_t;

endpackage

// ----- rtl/mbce_if.sv -----
// ---------------------------------------------------------------------------
// mbce_if
// Valid/ready channels for image bytes and expanded pixels.
// ---------------------------------------------------------------------------
interface mbce_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] image_byte;
  logic       start_of_image;

  modport source (output valid, output image_byte, output start_of_image, input ready);
  modport sink (input valid, input image_byte, input start_of_image, output ready);
endinterface

interface mbce_pix_if;
  logic        valid;
  logic        ready;
  logic [15:0] pixel_row;
  logic [15:0] pixel_col;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic        last_of_byte;
  logic        last_of_image;

  modport source (output valid, output pixel_row, output pixel_col, output red,
                  output green, output blue, output last_of_byte,
                  output last_of_image, input ready);
  modport sink (input valid, input pixel_row, input pixel_col, input red,
                input green, input blue, input last_of_byte,
                input last_of_image, output ready);
endinterface

// ----- rtl/mono_bitmap_color_expand.sv -----
// ---------------------------------------------------------------------------
// mono_bitmap_color_expand
// Expands a 1-bit-per-pixel image byte stream into colored pixel beats.
// ---------------------------------------------------------------------------
// Header bytes produce nothing. Each data byte becomes eight pixel beats, one
// per cycle while the pixel receiver is ready. A parsed byte is first written
// into the queue; its pixel beats are then built in the output register. A
// queue of QueueDepth tagged bytes sits between the header parser and the
// pixel engine, so input beats keep flowing while earlier bytes are still being
// expanded, until the queue is full.
// Colors are sampled as pixels are produced; write configuration only when idle.
module mono_bitmap_color_expand #(
  parameter int unsigned QueueDepth = mbce_pkg::QUEUE_DEPTH
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [mbce_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [mbce_pkg::COLOR_W-1:0]   cfg_data_i,
  mbce_byte_if.sink                      byte_i,
  mbce_pix_if.source                     pix_o
);
  import mbce_pkg::*;

  logic [COORD_W-1:0] origin_row_q, origin_col_q;
  logic [COLOR_W-1:0] color_zero_q, color_one_q;

  mbce_fifo_status_t fifo_st;
  mbce_entry_t       push_data, head;
  logic              push, pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_row_q <= '0;
      origin_col_q <= '0;
      color_zero_q <= '0;
      color_one_q  <= COLOR_ONE_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_ORIGIN_ROW: origin_row_q <= cfg_data_i[COORD_W-1:0];
        CFG_ORIGIN_COL: origin_col_q <= cfg_data_i[COORD_W-1:0];
        CFG_COLOR_ZERO: color_zero_q <= cfg_data_i;
        CFG_COLOR_ONE:  color_one_q  <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  mbce_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (byte_i.valid),
    .in_ready_o       (byte_i.ready),
    .image_byte_i     (byte_i.image_byte),
    .start_of_image_i (byte_i.start_of_image),
    .origin_row_i     (origin_row_q),
    .origin_col_i     (origin_col_q),
    .fifo_st_i        (fifo_st),
    .push_o           (push),
    .push_data_o      (push_data)
  );

  mbce_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .head_o      (head),
    .status_o    (fifo_st)
  );

  mbce_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .fifo_st_i    (fifo_st),
    .pop_o        (pop),
    .color_zero_i (color_zero_q),
    .color_one_i  (color_one_q),
    .pix_o        (pix_o)
  );

endmodule

// ----- rtl/mbce_front.sv -----
// ---------------------------------------------------------------------------
// mbce_front
// Parses the image header and tags each data byte with its row and column.
// ---------------------------------------------------------------------------
module mbce_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [7:0]                  image_byte_i,
  input  logic                        start_of_image_i,
  input  logic [15:0]                 origin_row_i,
  input  logic [15:0]                 origin_col_i,
  input  mbce_pkg::mbce_fifo_status_t fifo_st_i,
  output logic                        push_o,
  output mbce_pkg::mbce_entry_t       push_data_o
);
  import mbce_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'b001,
    PH_HEADER = 3'b010,
    PH_DATA   = 3'b100
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [1:0]  hdr_idx_q, hdr_idx_d;
  logic [7:0]  wid_hi_q, wid_hi_d;
  logic [12:0] bpl_q, bpl_d;
  logic [15:0] lines_q, lines_d;
  logic [15:0] line_q, line_d;
  logic [12:0] byte_q, byte_d;

  logic        accept;
  logic        last_in_line;
  logic        last_img;
  logic [15:0] width_px;
  logic [15:0] lines_full;

  assign in_ready_o = !fifo_st_i.full;
  assign accept     = in_valid_i && in_ready_o;

  assign width_px     = {wid_hi_q, image_byte_i};
  assign lines_full   = {lines_q[15:8], image_byte_i};
  assign last_in_line = ({1'b0, byte_q} + 14'd1) >= {1'b0, bpl_q};
  assign last_img     = last_in_line && (({1'b0, line_q} + 17'd1) >= {1'b0, lines_q});

  assign push_o               = accept && !start_of_image_i && (phase_q == PH_DATA);
  assign push_data_o.bits     = image_byte_i;
  assign push_data_o.row      = origin_row_i - line_q;
  assign push_data_o.col      = origin_col_i + {byte_q, 3'b000};
  assign push_data_o.last_img = last_img;

  always_comb begin
    phase_d   = phase_q;
    hdr_idx_d = hdr_idx_q;
    wid_hi_d  = wid_hi_q;
    bpl_d     = bpl_q;
    lines_d   = lines_q;
    line_d    = line_q;
    byte_d    = byte_q;
    if (accept) begin
      if (start_of_image_i) begin
        wid_hi_d  = image_byte_i;
        hdr_idx_d = 2'd1;
        phase_d   = PH_HEADER;
      end else begin
        case (phase_q)
          PH_HEADER: begin
            if (hdr_idx_q == 2'd1) begin
              bpl_d     = width_px[15:3];
              hdr_idx_d = 2'd2;
            end else if (hdr_idx_q == 2'd2) begin
              lines_d   = {image_byte_i, 8'h00};
              hdr_idx_d = 2'd3;
            end else begin
              lines_d   = lines_full;
              hdr_idx_d = 2'd0;
              line_d    = '0;
              byte_d    = '0;
              phase_d   = (bpl_q != '0 && lines_full != '0) ? PH_DATA : PH_IDLE;
            end
          end
          PH_DATA: begin
            if (last_img) begin
              phase_d = PH_IDLE;
              byte_d  = '0;
              line_d  = '0;
            end else if (last_in_line) begin
              byte_d = '0;
              line_d = line_q + 16'd1;
            end else begin
              byte_d = byte_q + 13'd1;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      hdr_idx_q <= '0;
      wid_hi_q  <= '0;
      bpl_q     <= '0;
      lines_q   <= '0;
      line_q    <= '0;
      byte_q    <= '0;
    end else begin
      phase_q   <= phase_d;
      hdr_idx_q <= hdr_idx_d;
      wid_hi_q  <= wid_hi_d;
      bpl_q     <= bpl_d;
      lines_q   <= lines_d;
      line_q    <= line_d;
      byte_q    <= byte_d;
    end
  end

endmodule

// ----- rtl/mbce_fifo.sv -----
// ---------------------------------------------------------------------------
// mbce_fifo
// Short queue of tagged data bytes between the parser and the pixel engine.
// ---------------------------------------------------------------------------
module mbce_fifo #(
  parameter int unsigned Depth = mbce_pkg::QUEUE_DEPTH
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push_i,
  input  mbce_pkg::mbce_entry_t       push_data_i,
  input  logic                        pop_i,
  output mbce_pkg::mbce_entry_t       head_o,
  output mbce_pkg::mbce_fifo_status_t status_o
);
  import mbce_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  mbce_entry_t     mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  assign status_o.full  = (count_q == CntW'(Depth));
  assign status_o.empty = (count_q == '0);
  assign head_o         = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

endmodule

// ----- rtl/mbce_back.sv -----
// ---------------------------------------------------------------------------
// mbce_back
// Expands the queued byte at the head into eight registered pixel beats.
// ---------------------------------------------------------------------------
module mbce_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  mbce_pkg::mbce_entry_t       head_i,
  input  mbce_pkg::mbce_fifo_status_t fifo_st_i,
  output logic                        pop_o,
  input  logic [23:0]                 color_zero_i,
  input  logic [23:0]                 color_one_i,
  mbce_pix_if.source                  pix_o
);
  import mbce_pkg::*;

  logic [2:0]  bit_q;
  logic        valid_q;
  logic        advance;
  logic        last_bit;
  logic        pix_bit;
  logic [23:0] color;

  logic [15:0] row_q, col_q;
  logic [23:0] color_q;
  logic        lob_q, loi_q;

  assign advance  = !fifo_st_i.empty && (!valid_q || pix_o.ready);
  assign last_bit = (bit_q == 3'd7);
  assign pop_o    = advance && last_bit;
  assign pix_bit  = head_i.bits[3'd7 - bit_q];
  assign color    = pix_bit ? color_one_i : color_zero_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      if (advance) begin
        bit_q   <= bit_q + 3'd1;
        valid_q <= 1'b1;
      end else if (pix_o.ready) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      row_q   <= head_i.row;
      col_q   <= head_i.col + {13'd0, bit_q};
      color_q <= color;
      lob_q   <= last_bit;
      loi_q   <= last_bit && head_i.last_img;
    end
  end

  assign pix_o.valid         = valid_q;
  assign pix_o.pixel_row     = row_q;
  assign pix_o.pixel_col     = col_q;
  assign pix_o.red           = color_q[23:16];
  assign pix_o.green         = color_q[15:8];
  assign pix_o.blue          = color_q[7:0];
  assign pix_o.last_of_byte  = lob_q;
  assign pix_o.last_of_image = loi_q;

endmodule

// ----- rtl/mbce_checker.sv -----
// ---------------------------------------------------------------------------
// mbce_checker
// Port-level checks on the pixel channel of the color expander.
// ---------------------------------------------------------------------------
`include "mono_bitmap_color_expand_assert.svh"

module mbce_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic pix_valid_i,
  input logic pix_ready_i,
  input logic last_of_byte_i,
  input logic last_of_image_i
);

  // A pending beat stays offered until it is taken.
  `MBCE_ASSERT(a_pix_hold, pix_valid_i && !pix_ready_i |=> pix_valid_i, "pixel beat dropped")

  `MBCE_ASSERT_ALWAYS(a_rst_quiet, !rst_ni |=> !pix_valid_i, "pixel beat during reset")

  `MBCE_ASSERT(a_last_img_byte, pix_valid_i && last_of_image_i |-> last_of_byte_i, "image end mid byte")

endmodule

bind mono_bitmap_color_expand mbce_checker u_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .pix_valid_i     (pix_o.valid),
  .pix_ready_i     (pix_o.ready),
  .last_of_byte_i  (pix_o.last_of_byte),
  .last_of_image_i (pix_o.last_of_image)
);

// ----- test/tb.sv -----
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the monochrome bitmap color expander. Image streams
// are sent over the byte channel. They are directed corner cases first, then
// random images, some of them truncated or interrupted. A behavioral model
// turns every accepted byte beat into the pixel beats it should produce. The
// pixel beats that come out are checked in order, field by field, against
// that model. Sender gaps, receiver stalls and one long output hold-off vary
// from phase to phase. The registers are rewritten between phases while the
// block is idle.
// ---------------------------------------------------------------------------
module tb;
  import mbce_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned MAX_REPORTS  = 40;

  typedef enum logic [1:0] {WAIT_START, IN_HEADER, IN_DATA} parse_state_e;

  typedef struct packed {
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    logic               last_byte;
    logic               last_img;
  } pixel_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [COLOR_W-1:0]   cfg_data_i;

  mbce_byte_if byte_if ();
  mbce_pix_if  pix_if ();

  mono_bitmap_color_expand dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .byte_i     (byte_if),
    .pix_o      (pix_if)
  );

  logic [COORD_W-1:0] cfg_origin_row;
  logic [COORD_W-1:0] cfg_origin_col;
  logic [COLOR_W-1:0] cfg_color_zero;
  logic [COLOR_W-1:0] cfg_color_one;

  parse_state_e parse_state;
  logic [1:0]   hdr_idx;
  logic [7:0]   width_hi;
  logic [12:0]  line_bytes;
  logic [15:0]  line_count;
  logic [15:0]  line_idx;
  logic [12:0]  byte_idx;

  pixel_t      pending_pixels[$];
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  int          tx_idle_pct = 0;
  int          rx_stall_pct = 0;
  int          hold_left = 0;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      pix_if.ready = 1'b0;
      hold_left--;
    end else begin
      pix_if.ready = ($urandom_range(0, 99) >= rx_stall_pct);
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    if (mismatches < MAX_REPORTS) begin
      $display("mismatch at cycle %0d: %s expected %h got %h", cycles, what, want, got);
    end
    mismatches++;
  endtask

  always @(posedge clk_i) begin : check_pixels
    pixel_t want;
    if (rst_ni && pix_if.valid && pix_if.ready) begin
      if (pending_pixels.size() == 0) begin
        report_mismatch("pixel beat with none pending", 32'd0, 32'd1);
      end else begin
        want = pending_pixels.pop_front();
        if (pix_if.pixel_row !== want.row)
          report_mismatch("pixel_row", 32'(want.row), 32'(pix_if.pixel_row));
        if (pix_if.pixel_col !== want.col)
          report_mismatch("pixel_col", 32'(want.col), 32'(pix_if.pixel_col));
        if (pix_if.red !== want.red)
          report_mismatch("red", 32'(want.red), 32'(pix_if.red));
        if (pix_if.green !== want.green)
          report_mismatch("green", 32'(want.green), 32'(pix_if.green));
        if (pix_if.blue !== want.blue)
          report_mismatch("blue", 32'(want.blue), 32'(pix_if.blue));
        if (pix_if.last_of_byte !== want.last_byte)
          report_mismatch("last_of_byte", 32'(want.last_byte), 32'(pix_if.last_of_byte));
        if (pix_if.last_of_image !== want.last_img)
          report_mismatch("last_of_image", 32'(want.last_img), 32'(pix_if.last_of_image));
      end
    end
  end

  task automatic expand_byte(input logic [7:0] b, input logic sop);
    pixel_t             px;
    logic [15:0]        width_px;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col_base;
    logic [COLOR_W-1:0] color;
    logic               line_end;
    logic               img_end;
    if (sop) begin
      width_hi    = b;
      hdr_idx     = 2'd1;
      parse_state = IN_HEADER;
    end else if (parse_state == IN_HEADER) begin
      if (hdr_idx == 2'd1) begin
        width_px   = {width_hi, b};
        line_bytes = width_px[15:3];
        hdr_idx    = 2'd2;
      end else if (hdr_idx == 2'd2) begin
        line_count = {b, 8'h00};
        hdr_idx    = 2'd3;
      end else begin
        line_count  = {line_count[15:8], b};
        hdr_idx     = 2'd0;
        line_idx    = '0;
        byte_idx    = '0;
        parse_state = (line_bytes != 0 && line_count != 0) ? IN_DATA : WAIT_START;
      end
    end else if (parse_state == IN_DATA) begin
      row      = cfg_origin_row - line_idx;
      col_base = cfg_origin_col + {byte_idx, 3'b000};
      line_end = (32'(byte_idx) + 1) >= 32'(line_bytes);
      img_end  = line_end && ((32'(line_idx) + 1) >= 32'(line_count));
      for (int k = 0; k < 8; k++) begin
        color        = b[7-k] ? cfg_color_one : cfg_color_zero;
        px.row       = row;
        px.col       = col_base + 16'(k);
        px.red       = color[23:16];
        px.green     = color[15:8];
        px.blue      = color[7:0];
        px.last_byte = (k == 7);
        px.last_img  = (k == 7) && img_end;
        pending_pixels.push_back(px);
      end
      if (img_end) begin
        parse_state = WAIT_START;
        byte_idx    = '0;
        line_idx    = '0;
      end else if (line_end) begin
        byte_idx = '0;
        line_idx = line_idx + 16'd1;
      end else begin
        byte_idx = byte_idx + 13'd1;
      end
    end
  endtask

  task automatic send_byte(input logic [7:0] value, input logic sop);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      byte_if.valid = 1'b0;
      @(negedge clk_i);
    end
    byte_if.valid          = 1'b1;
    byte_if.image_byte     = value;
    byte_if.start_of_image = sop;
    do @(posedge clk_i); while (!byte_if.ready);
    expand_byte(value, sop);
  endtask

  task automatic send_header(input logic [15:0] w, input logic [15:0] h);
    send_byte(w[15:8], 1'b1);
    send_byte(w[7:0], 1'b0);
    send_byte(h[15:8], 1'b0);
    send_byte(h[7:0], 1'b0);
  endtask

  task automatic settle_block();
    @(negedge clk_i);
    byte_if.valid = 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COLOR_W-1:0] value);
    @(negedge clk_i);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = value;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      CFG_ORIGIN_ROW: cfg_origin_row = value[COORD_W-1:0];
      CFG_ORIGIN_COL: cfg_origin_col = value[COORD_W-1:0];
      CFG_COLOR_ZERO: cfg_color_zero = value;
      CFG_COLOR_ONE:  cfg_color_one  = value;
      default: ;
    endcase
  endtask

  task automatic load_config(input logic [15:0] row, input logic [15:0] col,
                             input logic [23:0] zero, input logic [23:0] one);
    settle_block();
    write_reg(CFG_ORIGIN_ROW, {8'h00, row});
    write_reg(CFG_ORIGIN_COL, {8'h00, col});
    write_reg(CFG_COLOR_ZERO, zero);
    write_reg(CFG_COLOR_ONE, one);
  endtask

  task automatic load_random_config();
    load_config(16'($urandom), 16'($urandom), 24'($urandom), 24'($urandom));
  endtask

  task automatic send_random_image(inout int budget);
    int          kind;
    int          nbytes;
    logic [15:0] w;
    logic [15:0] h;
    kind = $urandom_range(0, 99);
    if (kind < 6) begin
      repeat ($urandom_range(1, 3)) send_byte(8'($urandom), 1'b0);
    end else if (kind < 12) begin
      nbytes = $urandom_range(1, 3);
      w      = 16'($urandom);
      send_byte(w[15:8], 1'b1);
      if (nbytes > 1) send_byte(w[7:0], 1'b0);
      if (nbytes > 2) send_byte(8'($urandom), 1'b0);
      budget -= nbytes;
    end else begin
      if (kind < 20) begin
        w = 16'($urandom_range(0, 7));
        h = 16'($urandom_range(0, 3));
      end else if (kind < 26) begin
        w = 16'($urandom_range(8, 63));
        h = 16'd0;
      end else if (kind < 32) begin
        w = 16'($urandom);
        h = 16'($urandom);
      end else begin
        w = 16'($urandom_range(8, 39));
        h = 16'($urandom_range(1, 4));
      end
      send_header(w, h);
      budget -= 4;
      nbytes = int'(w[15:3]) * int'(h);
      if (kind < 32 || kind >= 92) begin
        nbytes = $urandom_range(0, (nbytes < 10) ? nbytes : 10);
      end
      repeat (nbytes) send_byte(8'($urandom), 1'b0);
      budget -= nbytes;
      if (kind >= 32 && kind < 92 && $urandom_range(0, 4) == 0) begin
        send_byte(8'($urandom), 1'b0);
      end
    end
  endtask

  task automatic run_random_phase(input int tx_pct, input int rx_pct, input int items);
    int budget;
    budget       = items;
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
    while (budget > 0) begin
      send_random_image(budget);
      if ($urandom_range(0, 7) == 0) settle_block();
    end
    send_header(16'h0000, 16'h0000);
  endtask

  task automatic test_directed_cases();
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    load_config(16'h0000, 16'hFFF8, 24'h000000, 24'hFFFFFF);
    send_byte(8'hFF, 1'b1);
    send_header(16'hFFFF, 16'hFFFF);
    send_byte(8'h81, 1'b0);
    send_byte(8'h7E, 1'b0);
    send_header(16'h0010, 16'h0002);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hA5, 1'b0);
    send_byte(8'h5A, 1'b0);
    send_byte(8'h3C, 1'b0);
    send_header(16'h0007, 16'h0003);
    send_header(16'h0008, 16'h0000);
  endtask

  task automatic test_no_idle();
    load_random_config();
    run_random_phase(0, 0, 65);
  endtask

  task automatic test_sender_idle();
    load_config(16'hFFFF, 16'hFFFF, 24'hFFFFFF, 24'h000000);
    run_random_phase(61, 0, 65);
  endtask

  task automatic test_receiver_stall();
    load_random_config();
    run_random_phase(0, 61, 65);
  endtask

  task automatic test_both_idle();
    load_config(16'h0000, 16'h0000, 24'($urandom), 24'($urandom));
    run_random_phase(34, 34, 65);
  endtask

  task automatic test_output_hold();
    load_random_config();
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    hold_left    = HOLD_CYCLES;
    send_header(16'h0020, 16'h0004);
    repeat (16) send_byte(8'($urandom), 1'b0);
  endtask

  initial begin
    rst_ni                 = 1'b0;
    cfg_we_i               = 1'b0;
    cfg_idx_i              = CFG_ORIGIN_ROW;
    cfg_data_i             = '0;
    byte_if.valid          = 1'b0;
    byte_if.image_byte     = '0;
    byte_if.start_of_image = 1'b0;
    pix_if.ready           = 1'b0;
    cfg_origin_row         = '0;
    cfg_origin_col         = '0;
    cfg_color_zero         = '0;
    cfg_color_one          = COLOR_ONE_RESET;
    parse_state            = WAIT_START;
    hdr_idx                = '0;
    width_hi               = '0;
    line_bytes             = '0;
    line_count             = '0;
    line_idx               = '0;
    byte_idx               = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed_cases();
    test_no_idle();
    test_sender_idle();
    test_receiver_stall();
    test_both_idle();
    test_output_hold();
    settle_block();

    if (mismatches == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
